[hdl/als_pkg.sv]
// ---------------------------------------------------------------------------
// als_pkg: shared constants and codes for the adjacency list store
// Operation kinds, status codes and default sizes.
// ---------------------------------------------------------------------------
package als_pkg;
    localparam int MaxNodes  = 16;
    localparam int MaxDegree = 8;

    localparam logic [2:0] K_ADD_NODE = 3'd0;
    localparam logic [2:0] K_ADD_EDGE = 3'd1;
    localparam logic [2:0] K_REM_EDGE = 3'd2;
    localparam logic [2:0] K_REM_NODE = 3'd3;
    localparam logic [2:0] K_READ     = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_PARENT = 3'd1;
    localparam logic [2:0] ST_BAD_NODE   = 3'd2;
    localparam logic [2:0] ST_BAD_EDGE   = 3'd3;
    localparam logic [2:0] ST_FULL       = 3'd4;
endpackage

[hdl/als_ram.sv]
// ---------------------------------------------------------------------------
// als_ram: generic simple dual-port RAM (separate write and read ports)
// One write and one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module als_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/adjacency_list_store_top.sv]
// ---------------------------------------------------------------------------
// adjacency_list_store_top: bounded directed-graph store
// Node values, list lengths and neighbour lists held in RAMs; a sequencer
// works each operation through them one entry per step.
// ---------------------------------------------------------------------------
// Input channel: i_valid / o_stall, fields kind, value, has_parent,
// first_index, second_index, slot. Output channel: o_valid / i_stall with
// one result item per input item.
// o_stall is high from acceptance until the result item is loaded into the
// output register; one item is worked at a time.
// Path from acceptance to o_valid: error outcomes, kinds 5 to 7 and reads
// of an empty slot go S_RD, S_DEC, S_OUT; add node with a parent, add edge
// and reads of a neighbour add S_FX_LN or S_RDN. Remove edge loops S_RE_RD
// and S_RE_CK over each list entry. Remove node shifts the node table
// (S_SH_RD/S_SH_WR over all MAX_DEGREE slots per node above the victim)
// and then rewrites every remaining list with S_FX_RD/S_FX_CK per entry.
// The input is free again as soon as the result is loaded.
// Reset clears the node count and the sequencer; RAM contents are not
// cleared since no entry's value is used before it is written.
// While i_stall is high the result holds; one further item may be taken
// and worked, and its result then waits until the held one is taken.
// ---------------------------------------------------------------------------
module adjacency_list_store_top #(
    parameter int MAX_NODES  = als_pkg::MaxNodes,
    parameter int MAX_DEGREE = als_pkg::MaxDegree
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [63:0] i_value,
    input  logic        i_has_parent,
    input  logic [3:0]  i_first_index,
    input  logic [3:0]  i_second_index,
    input  logic [2:0]  i_slot,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_new_node,
    output logic [4:0]  o_node_count,
    output logic [63:0] o_node_value,
    output logic [3:0]  o_degree,
    output logic [3:0]  o_neighbour
);
    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int SW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int LD = MAX_NODES * MAX_DEGREE;
    localparam int LW = $clog2(LD) + ((LD == 1) ? 1 : 0);
    localparam int NEW = (NW > 0) ? NW : 1;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_RD    = 12'b000000000010,
        S_DEC   = 12'b000000000100,
        S_RE_RD = 12'b000000001000,
        S_RE_CK = 12'b000000010000,
        S_SH_RD = 12'b000000100000,
        S_SH_WR = 12'b000001000000,
        S_FX_RD = 12'b000010000000,
        S_FX_CK = 12'b000100000000,
        S_FX_LN = 12'b001000000000,
        S_RDN   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [2:0]  r_kind;
    logic [63:0] r_value;
    logic        r_hasp;
    logic [3:0]  r_a, r_b;
    logic [2:0]  r_slot;
    logic [NEW-1:0] r_node, n_node;
    logic [DW-1:0]  r_j, n_j, r_k, n_k, r_len, n_len;
    logic [2:0]  r_status, n_status;
    logic [3:0]  r_new, n_new;
    logic [63:0] r_oval, n_oval;
    logic [3:0]  r_odeg, n_odeg, r_onb, n_onb;
    logic        r_found, n_found;
    logic        r_ovalid, n_ovalid;

    logic          v_we, l_we, g_we;
    logic [NEW-1:0] v_wa, v_ra, l_wa, l_ra;
    logic [63:0]   v_wd, v_rd;
    logic [DW-1:0] l_wd, l_rd;
    logic [LW-1:0] g_wa, g_ra;
    logic [3:0]    g_wd;
    logic [3:0]    g_rd;

    als_ram #(.WIDTH(64), .DEPTH(MAX_NODES)) u_val (
        .i_clk, .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_raddr(v_ra), .o_rdata(v_rd));
    als_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_len (
        .i_clk, .i_we(l_we), .i_waddr(l_wa), .i_wdata(l_wd),
        .i_raddr(l_ra), .o_rdata(l_rd));
    als_ram #(.WIDTH(4), .DEPTH(LD)) u_lst (
        .i_clk, .i_we(g_we), .i_waddr(g_wa), .i_wdata(g_wd),
        .i_raddr(g_ra), .o_rdata(g_rd));

    function automatic logic [LW-1:0] ladr(input logic [NEW-1:0] n,
                                           input logic [DW-1:0] s);
        logic [LW+DW:0] t;
        t = (LW+DW+1)'(n) * (LW+DW+1)'(MAX_DEGREE) + (LW+DW+1)'(s);
        return t[LW-1:0];
    endfunction

    logic [3:0]  a_w;
    logic [CW:0] a_ext, b_ext, node_ext;
    logic        a_ok, b_ok;
    assign a_ext    = (CW+1)'(r_a);
    assign b_ext    = (CW+1)'(r_b);
    assign node_ext = (CW+1)'(r_node);
    assign a_ok = a_ext < (CW+1)'(r_count);
    assign b_ok = b_ext < (CW+1)'(r_count);
    assign a_w  = r_a;

    logic [3:0] vict;
    assign vict = r_a;

    always_comb begin
        n_state = r_state; n_count = r_count; n_node = r_node;
        n_j = r_j; n_k = r_k; n_len = r_len; n_status = r_status;
        n_new = r_new; n_oval = r_oval; n_odeg = r_odeg; n_onb = r_onb;
        n_found = r_found; n_ovalid = r_ovalid;
        v_we = 1'b0; v_wa = r_node; v_wd = r_value; v_ra = r_a[NEW-1:0];
        l_we = 1'b0; l_wa = r_a[NEW-1:0]; l_wd = r_len; l_ra = r_a[NEW-1:0];
        g_we = 1'b0; g_wa = ladr(r_node, r_k); g_wd = r_b;
        g_ra = ladr(r_node, r_j);
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_status = als_pkg::ST_OK; n_new = '0; n_oval = '0;
                n_odeg = '0; n_onb = '0; n_j = '0; n_k = '0; n_found = 1'b0;
                n_node = r_a[NEW-1:0];
                n_state = S_DEC;
            end
            S_DEC: begin
                n_len = l_rd;
                n_state = S_OUT;
                case (r_kind)
                    als_pkg::K_ADD_NODE: begin
                        if (r_count >= CW'(MAX_NODES) ||
                            (r_hasp && a_ok && l_rd >= DW'(MAX_DEGREE))) begin
                            n_status = als_pkg::ST_FULL;
                        end else begin
                            n_new = 4'(r_count);
                            v_we = 1'b1; v_wa = r_count[NEW-1:0];
                            l_we = 1'b1; l_wa = r_count[NEW-1:0]; l_wd = '0;
                            n_count = r_count + 1'b1;
                            if (r_hasp && a_ok) begin
                                g_we = 1'b1; g_wa = ladr(r_a[NEW-1:0], l_rd);
                                g_wd = 4'(r_count);
                                if (r_count[NEW-1:0] != r_a[NEW-1:0]) begin
                                    n_len = l_rd + 1'b1;
                                    n_state = S_FX_LN;
                                end
                            end else if (r_hasp) begin
                                n_status = als_pkg::ST_BAD_PARENT;
                            end
                        end
                    end
                    als_pkg::K_ADD_EDGE: begin
                        if (!a_ok || !b_ok) begin
                            n_status = als_pkg::ST_BAD_EDGE;
                        end else if (l_rd >= DW'(MAX_DEGREE)) begin
                            n_status = als_pkg::ST_FULL;
                        end else begin
                            g_we = 1'b1; g_wa = ladr(r_a[NEW-1:0], l_rd);
                            n_len = l_rd + 1'b1;
                            n_state = S_FX_LN;
                        end
                    end
                    als_pkg::K_REM_EDGE: begin
                        n_status = als_pkg::ST_BAD_EDGE;
                        if (a_ok) begin
                            n_state = S_RE_RD;
                        end
                    end
                    als_pkg::K_REM_NODE: begin
                        if (!a_ok) begin
                            n_status = als_pkg::ST_BAD_NODE;
                        end else begin
                            n_state = S_SH_RD;
                        end
                    end
                    als_pkg::K_READ: begin
                        if (!a_ok) begin
                            n_status = als_pkg::ST_BAD_NODE;
                        end else begin
                            n_odeg = 4'(l_rd);
                            n_oval = v_rd;
                            g_ra = ladr(r_a[NEW-1:0], DW'(r_slot));
                            if ((DW+1)'(r_slot) < (DW+1)'(l_rd)) begin
                                n_state = S_RDN;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_RDN: begin
                n_onb = g_rd;
                n_state = S_OUT;
            end
            S_RE_RD: begin
                // compact list of r_node, dropping the first match
                if (r_j >= r_len) begin
                    l_we = 1'b1; l_wa = r_node; l_wd = r_k;
                    n_state = S_OUT;
                end else begin
                    n_state = S_RE_CK;
                end
            end
            S_RE_CK: begin
                n_j = r_j + 1'b1;
                n_state = S_RE_RD;
                if (!r_found && g_rd == r_b) begin
                    n_found = 1'b1; n_status = als_pkg::ST_OK;
                end else begin
                    g_we = 1'b1; g_wd = g_rd; n_k = r_k + 1'b1;
                end
                g_ra = ladr(r_node, n_j);
            end
            S_SH_RD: begin
                // move node r_node+1 down into r_node
                if (node_ext + 1'b1 >= (CW+1)'(r_count)) begin
                    n_count = r_count - 1'b1;
                    n_node = '0; n_j = '0; n_k = '0;
                    l_ra = '0;
                    n_state = S_FX_RD;
                end else begin
                    v_ra = NEW'(node_ext + 1'b1);
                    l_ra = NEW'(node_ext + 1'b1);
                    g_ra = ladr(NEW'(node_ext + 1'b1), r_j);
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                g_we = 1'b1; g_wa = ladr(r_node, r_j); g_wd = g_rd;
                v_ra = NEW'(node_ext + 1'b1);
                l_ra = NEW'(node_ext + 1'b1);
                if (r_j == DW'(MAX_DEGREE - 1)) begin
                    v_we = 1'b1; v_wd = v_rd;
                    l_we = 1'b1; l_wa = r_node; l_wd = l_rd;
                    n_j = '0; n_node = r_node + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
                n_state = S_SH_RD;
            end
            S_FX_RD: begin
                // fix list of r_node: drop victim, renumber higher
                if (node_ext >= (CW+1)'(r_count)) begin
                    n_state = S_OUT;
                end else begin
                    n_len = l_rd; n_j = '0; n_k = '0;
                    g_ra = ladr(r_node, '0);
                    n_state = S_FX_CK;
                end
            end
            S_FX_CK: begin
                if (r_j >= r_len) begin
                    l_we = 1'b1; l_wa = r_node; l_wd = r_k;
                    n_node = r_node + 1'b1;
                    l_ra = NEW'(node_ext + 1'b1);
                    n_state = S_FX_RD;
                end else begin
                    if (g_rd != vict) begin
                        g_we = 1'b1;
                        g_wd = (g_rd > vict) ? g_rd - 1'b1 : g_rd;
                        n_k = r_k + 1'b1;
                    end
                    n_j = r_j + 1'b1;
                    g_ra = ladr(r_node, n_j);
                end
            end
            S_FX_LN: begin
                l_we = 1'b1; l_wa = a_w[NEW-1:0]; l_wd = r_len;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_ovalid <= n_ovalid;
        end
        r_node <= n_node; r_j <= n_j; r_k <= n_k; r_len <= n_len;
        r_status <= n_status; r_new <= n_new; r_oval <= n_oval;
        r_odeg <= n_odeg; r_onb <= n_onb; r_found <= n_found;
        if (r_state == S_IDLE && i_valid) begin
            r_kind <= i_kind; r_value <= i_value; r_hasp <= i_has_parent;
            r_a <= i_first_index; r_b <= i_second_index; r_slot <= i_slot;
        end
    end

    logic [4:0] r_out_cnt;
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
            o_status <= r_status; o_new_node <= r_new;
            o_node_value <= r_oval; o_degree <= r_odeg;
            o_neighbour <= r_onb; r_out_cnt <= 5'(r_count);
        end
    end
    assign o_node_count = r_out_cnt;
    assign o_valid = r_ovalid;
    assign o_stall = (r_state != S_IDLE);

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_NODES)) else $error("node count overflow");
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> o_stall) else $error("not busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_status))
        else $error("result dropped");
endmodule
